// ===== sv/pot_position_pd_controller_defines.svh =====
// Assertion macros for the controller's top-level RTL file.
`ifndef POT_POSITION_PD_CONTROLLER_DEFINES_SVH
`define POT_POSITION_PD_CONTROLLER_DEFINES_SVH

// Checked at every rising edge of clk_i, switched off while rst_ni is low.
`define PDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define PDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/pdc_pkg.sv =====
package pdc_pkg;

  // Field and register widths fixed by the block's interface.
  localparam int unsigned GAIN_W      = 14;
  localparam int unsigned DEADBAND_W  = 10;
  localparam int unsigned LIMIT_W     = 10;
  localparam int unsigned DRIVE_W     = 11;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 14;

  // The target is scaled onto 0..SCALED_MAX, which needs SCALED_W bits.
  localparam int unsigned SCALED_MAX = 830;
  localparam int unsigned SCALED_W   = 10;

  localparam logic [GAIN_W-1:0]     PROP_GAIN_RST   = 14'd794;
  localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST  = 14'd3840;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST    = 10'd10;
  localparam logic [LIMIT_W-1:0]    DRIVE_LIMIT_RST = 10'd512;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_DERIV_GAIN  = 2'd1,
    REG_DEADBAND    = 2'd2,
    REG_DRIVE_LIMIT = 2'd3
  } pdc_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_MAC   = 4'b0100,
    ST_FIN   = 4'b1000
  } pdc_state_e;

  // Progress of a serial unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } pdc_seq_t;

endpackage

// ===== sv/pdc_scaler.sv =====
// Restoring divider by a constant, one quotient bit per cycle.
module pdc_scaler #(
  parameter int unsigned           DIVIDEND_W = 20,
  parameter int unsigned           DIVISOR_W  = 10,
  parameter logic [DIVISOR_W-1:0]  DIVISOR    = '1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output pdc_pkg::pdc_seq_t     status_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] num_q, num_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    trial  = {rem_q, num_q[DIVIDEND_W-1]};
    diff   = trial - {1'b0, DIVISOR};
    fits   = trial >= {1'b0, DIVISOR};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The quotient bits move in from the bottom as the dividend leaves at the top.
      num_d = {num_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = num_q;

endmodule

// ===== sv/pdc_mac.sv =====
// Bit-serial sum of two products, gains consumed from the top bit down.
module pdc_mac #(
  parameter int unsigned ERR_W = 11,
  parameter int unsigned ACC_W = 27
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ERR_W-1:0]            err_i,
  input  logic [ERR_W:0]              deriv_i,
  input  logic [pdc_pkg::GAIN_W-1:0]  kp_i,
  input  logic [pdc_pkg::GAIN_W-1:0]  kd_i,
  output pdc_pkg::pdc_seq_t           status_o,
  output logic [ACC_W-1:0]            acc_o
);

  localparam int unsigned GW    = pdc_pkg::GAIN_W;
  localparam int unsigned DER_W = ERR_W + 1;
  localparam int unsigned CNT_W = $clog2(GW + 1);

  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] err_q, err_d;
  logic [ACC_W-1:0] der_q, der_d;
  logic [GW-1:0]    kp_q, kp_d;
  logic [GW-1:0]    kd_q, kd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [ACC_W-1:0] p_term;
  logic [ACC_W-1:0] d_term;

  always_comb begin
    p_term = kp_q[GW-1] ? err_q : '0;
    d_term = kd_q[GW-1] ? der_q : '0;
    acc_d  = acc_q;
    err_d  = err_q;
    der_d  = der_q;
    kp_d   = kp_q;
    kd_d   = kd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      err_d  = {{(ACC_W-ERR_W){err_i[ERR_W-1]}}, err_i};
      der_d  = {{(ACC_W-DER_W){deriv_i[DER_W-1]}}, deriv_i};
      kp_d   = kp_i;
      kd_d   = kd_i;
      cnt_d  = CNT_W'(GW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Horner form: double the running sum, then add the terms picked by this gain bit.
      acc_d = {acc_q[ACC_W-2:0], 1'b0} + p_term + d_term;
      kp_d  = {kp_q[GW-2:0], 1'b0};
      kd_d  = {kd_q[GW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    err_q <= err_d;
    der_q <= der_d;
    kp_q  <= kp_d;
    kd_q  <= kd_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign acc_o         = acc_q;

endmodule

// ===== sv/pot_position_pd_controller.sv =====
// Position controller for a potentiometer-sensed actuator. Each request carries a
// position sample and a target; the target is scaled onto 0..830, the error and its
// change since the previous request give the drive err*kp + deriv*kd (gains unsigned,
// GAIN_FRAC_BITS fractional bits), truncated toward zero and clamped to the drive limit.
// An error magnitude below the deadband forces the drive to zero and raises at_target.
// Requests are handled one at a time: the bit-serial target scaler runs first, then
// the bit-serial gain multiplier, the rest is sequencing. A new request is taken while
// the previous result still waits on the output. The user must write gains, deadband
// and limit through the cfg port only while no request is in flight; the block itself
// does not enforce this.
`include "pot_position_pd_controller_defines.svh"

module pot_position_pd_controller #(
  parameter int unsigned SAMPLE_BITS    = 10,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Configuration writes.
  input  logic                                       cfg_we_i,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0]             cfg_addr_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]             cfg_wdata_i,
  // Requests: tdata = position_sample, target_position, zero padding.
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata_i,
  // Results: tdata = drive (signed), zero padding; tuser = at_target.
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  output logic [pdc_pkg::OUT_TDATA_W-1:0]            m_axis_tdata_o,
  output logic                                       m_axis_tuser_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SCW   = pdc_pkg::SCALED_W;
  localparam int unsigned PW    = SB + SCW;
  localparam int unsigned EW    = ((SB > SCW) ? SB : SCW) + 1;
  localparam int unsigned DW    = EW + 1;
  localparam int unsigned AW    = DW + pdc_pkg::GAIN_W + 1;
  localparam int unsigned QW    = AW - GAIN_FRAC_BITS;
  localparam int unsigned LW    = pdc_pkg::LIMIT_W;
  localparam int unsigned DRW   = pdc_pkg::DRIVE_W;

  pdc_pkg::pdc_state_e state_q, state_d;

  logic [pdc_pkg::GAIN_W-1:0]     kp_q, kd_q;
  logic [pdc_pkg::DEADBAND_W-1:0] deadband_q;
  logic [LW-1:0]                  limit_q;

  logic [SB-1:0]  sample_q;
  logic [EW-1:0]  err_q, prev_q;
  logic [DRW-1:0] m_drive_q, m_drive_d;
  logic           m_at_q, m_at_d;
  logic           m_valid_q, m_valid_d;

  logic            s_hs;
  logic            load;
  logic [SB-1:0]   in_sample;
  logic [SB-1:0]   in_target;
  logic [PW-1:0]   dividend;
  logic [PW-1:0]   quotient;
  logic [EW-1:0]   err_now;
  logic [DW-1:0]   deriv_now;
  logic [AW-1:0]   acc;
  pdc_pkg::pdc_seq_t scl_st, mac_st;

  logic signed [QW-1:0] q_floor, q_trunc, lim_pos, lim_neg, q_sat;
  logic                 round_up;
  logic [EW-1:0]        err_mag;
  logic                 in_band;

  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == pdc_pkg::ST_IDLE);
  assign in_sample       = s_axis_tdata_i[SB-1:0];
  assign in_target       = s_axis_tdata_i[2*SB-1:SB];
  assign dividend        = PW'(in_target) * PW'(pdc_pkg::SCALED_MAX);

  // Divisor is full scale, 2^SAMPLE_BITS - 1.
  pdc_scaler #(
    .DIVIDEND_W (PW),
    .DIVISOR_W  (SB),
    .DIVISOR    ({SB{1'b1}})
  ) u_scaler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_hs),
    .dividend_i (dividend),
    .status_o   (scl_st),
    .quotient_o (quotient)
  );

  assign err_now   = {{(EW-SB){1'b0}}, sample_q} - {{(EW-SCW){1'b0}}, quotient[SCW-1:0]};
  assign deriv_now = {err_now[EW-1], err_now} - {prev_q[EW-1], prev_q};

  pdc_mac #(
    .ERR_W (EW),
    .ACC_W (AW)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scl_st.done),
    .err_i    (err_now),
    .deriv_i  (deriv_now),
    .kp_i     (kp_q),
    .kd_i     (kd_q),
    .status_o (mac_st),
    .acc_o    (acc)
  );

  // Shift out the fraction, truncating toward zero, then clamp and apply the deadband.
  always_comb begin
    q_floor  = acc[AW-1:GAIN_FRAC_BITS];
    round_up = acc[AW-1] && (|acc[GAIN_FRAC_BITS-1:0]);
    q_trunc  = q_floor + QW'(round_up);
    lim_pos  = {{(QW-LW){1'b0}}, limit_q};
    lim_neg  = -lim_pos;
    if (q_trunc > lim_pos) begin
      q_sat = lim_pos;
    end else if (q_trunc < lim_neg) begin
      q_sat = lim_neg;
    end else begin
      q_sat = q_trunc;
    end
    err_mag = err_q[EW-1] ? (~err_q + 1'b1) : err_q;
    in_band = err_mag < {{(EW-pdc_pkg::DEADBAND_W){1'b0}}, deadband_q};
    m_drive_d = in_band ? '0 : q_sat[DRW-1:0];
    m_at_d    = in_band;
  end

  assign load = (state_q == pdc_pkg::ST_FIN) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    m_valid_d = m_valid_q;
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pdc_pkg::ST_IDLE: begin
        if (s_hs) state_d = pdc_pkg::ST_SCALE;
      end
      pdc_pkg::ST_SCALE: begin
        if (scl_st.done) state_d = pdc_pkg::ST_MAC;
      end
      pdc_pkg::ST_MAC: begin
        if (mac_st.done) state_d = pdc_pkg::ST_FIN;
      end
      pdc_pkg::ST_FIN: begin
        if (load) state_d = pdc_pkg::ST_IDLE;
      end
      default: state_d = pdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pdc_pkg::ST_IDLE;
      m_valid_q  <= 1'b0;
      prev_q     <= '0;
      kp_q       <= pdc_pkg::PROP_GAIN_RST;
      kd_q       <= pdc_pkg::DERIV_GAIN_RST;
      deadband_q <= pdc_pkg::DEADBAND_RST;
      limit_q    <= pdc_pkg::DRIVE_LIMIT_RST;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (load) prev_q <= err_q;
      if (cfg_we_i) begin
        case (pdc_pkg::pdc_reg_e'(cfg_addr_i))
          pdc_pkg::REG_PROP_GAIN:   kp_q       <= cfg_wdata_i[pdc_pkg::GAIN_W-1:0];
          pdc_pkg::REG_DERIV_GAIN:  kd_q       <= cfg_wdata_i[pdc_pkg::GAIN_W-1:0];
          pdc_pkg::REG_DEADBAND:    deadband_q <= cfg_wdata_i[pdc_pkg::DEADBAND_W-1:0];
          pdc_pkg::REG_DRIVE_LIMIT: limit_q    <= cfg_wdata_i[LW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) sample_q <= in_sample;
    if (scl_st.done) err_q <= err_now;
    if (load) begin
      m_drive_q <= m_drive_d;
      m_at_q    <= m_at_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(pdc_pkg::OUT_TDATA_W-DRW){1'b0}}, m_drive_q};
  assign m_axis_tuser_o  = m_at_q;

  `PDC_ASSERT(a_accept_starts_scale, s_hs |=> (state_q == pdc_pkg::ST_SCALE),
              "accepted request did not start the scaler")
  `PDC_ASSERT(a_result_from_fin, $rose(m_valid_q) |-> $past(state_q == pdc_pkg::ST_FIN),
              "result appeared without a finished computation")
  `PDC_ASSERT(a_deadband_zero, (m_valid_q && m_at_q) |-> (m_drive_q == '0),
              "drive not zero inside the deadband")
  `PDC_ASSERT_ALWAYS(a_units_exclusive, !(scl_st.busy && mac_st.busy),
                     "scaler and multiplier busy together")

endmodule
